FILE: rtl/core/pvs_pkg.sv
// Package for the preemption victim selector.
// Holds slot status codes, the position cap and the item structs used by the core modules.
// No dependencies.
package pvs_pkg;

   localparam logic [1:0] ST_OTHER   = 2'd0;
   localparam logic [1:0] ST_WAITING = 2'd1;
   localparam logic [1:0] ST_RUNNING = 2'd2;

   localparam int POS_CAP = 16;

   typedef struct packed {
      logic [1:0] slot_status;
      logic [7:0] app_id;
      logic [7:0] task_id;
      logic [4:0] app_occupancy;
      logic [7:0] app_threshold;
      logic       last_slot;
   } req_item_type;

   typedef struct packed {
      logic       victim_found;
      logic [3:0] victim_slot;
      logic [7:0] victim_excess;
   } rsp_item_type;

endpackage

FILE: rtl/core/pvs_req_if.sv
// Slot item channel: valid/ready handshake with the per-slot fields.
// Depends on nothing; widths match pvs_pkg::req_item_type.
interface pvs_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] slot_status;
   logic [7:0] app_id;
   logic [7:0] task_id;
   logic [4:0] app_occupancy;
   logic [7:0] app_threshold;
   logic       last_slot;

   modport source (
      output valid, slot_status, app_id, task_id, app_occupancy, app_threshold, last_slot,
      input  ready
   );
   modport sink (
      input  valid, slot_status, app_id, task_id, app_occupancy, app_threshold, last_slot,
      output ready
   );
endinterface

FILE: rtl/core/pvs_rsp_if.sv
// Result channel: valid/ready handshake with the victim choice fields.
// Depends on nothing; widths match pvs_pkg::rsp_item_type.
interface pvs_rsp_if;
   logic       valid;
   logic       ready;
   logic       victim_found;
   logic [3:0] victim_slot;
   logic [7:0] victim_excess;

   modport source (
      output valid, victim_found, victim_slot, victim_excess,
      input  ready
   );
   modport sink (
      input  valid, victim_found, victim_slot, victim_excess,
      output ready
   );
endinterface

FILE: rtl/core/pvs_in_stage.sv
// Input register of the selector: captures one slot item per handshake.
// Depends on pvs_pkg and pvs_req_if.
module pvs_in_stage (
   input  logic                 clock,
   input  logic                 reset,
   pvs_req_if.sink              req_ch,
   input  logic                 consume,
   output logic                 item_valid,
   output pvs_pkg::req_item_type item
);

   logic                  valid_ff;
   logic                  valid_in;
   pvs_pkg::req_item_type item_ff;
   logic                  load;

   assign req_ch.ready = !valid_ff || consume;
   assign load         = req_ch.valid && req_ch.ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (consume) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff.slot_status   <= req_ch.slot_status;
         item_ff.app_id        <= req_ch.app_id;
         item_ff.task_id       <= req_ch.task_id;
         item_ff.app_occupancy <= req_ch.app_occupancy;
         item_ff.app_threshold <= req_ch.app_threshold;
         item_ff.last_slot     <= req_ch.last_slot;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

FILE: rtl/core/pvs_select.sv
// Scan state and victim compare: one slot item per cycle, a last one only if out_free.
// Depends on pvs_pkg.
module pvs_select #(
   parameter int POS_LIMIT = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  item_valid,
   input  pvs_pkg::req_item_type item,
   input  logic                  out_free,
   output logic                  consume,
   output logic                  rsp_load,
   output pvs_pkg::rsp_item_type rsp_item
);

   logic [7:0] best_excess_ff,  best_excess_in,  best_next;
   logic       have_choice_ff,  have_choice_in,  have_next;
   logic [3:0] chosen_index_ff, chosen_index_in, index_next;
   logic [7:0] chosen_app_ff,   chosen_app_in,   app_next;
   logic [7:0] chosen_task_ff,  chosen_task_in,  task_next;
   logic [3:0] slot_pos_ff,     slot_pos_in;

   logic [8:0] diff;
   logic       excess_gt;
   logic       excess_eq;
   logic       same_later;
   logic [4:0] pos_plus;

   assign consume  = item_valid && (!item.last_slot || out_free);
   assign rsp_load = consume && item.last_slot;

   assign diff       = {4'd0, item.app_occupancy} - {1'b0, item.app_threshold};
   assign excess_gt  = !diff[8] && (diff[7:0] > best_excess_ff);
   assign excess_eq  = !diff[8] && (diff[7:0] == best_excess_ff);
   assign same_later = (item.app_id == chosen_app_ff) && (item.task_id > chosen_task_ff);
   assign pos_plus   = {1'b0, slot_pos_ff} + 5'd1;

   always_comb begin
      best_next  = best_excess_ff;
      have_next  = have_choice_ff;
      index_next = chosen_index_ff;
      app_next   = chosen_app_ff;
      task_next  = chosen_task_ff;
      if (item.slot_status == pvs_pkg::ST_WAITING) begin
         if (excess_gt) begin
            best_next  = diff[7:0];
            have_next  = 1'b1;
            index_next = slot_pos_ff;
            app_next   = item.app_id;
            task_next  = item.task_id;
         end else if (excess_eq && have_choice_ff && same_later) begin
            index_next = slot_pos_ff;
            task_next  = item.task_id;
         end
      end else if (item.slot_status == pvs_pkg::ST_RUNNING) begin
         if (have_choice_ff && same_later) begin
            have_next = 1'b0;
         end
      end
   end

   always_comb begin
      rsp_item.victim_found  = have_next;
      rsp_item.victim_slot   = have_next ? index_next : 4'd0;
      rsp_item.victim_excess = best_next;
   end

   always_comb begin
      best_excess_in  = best_excess_ff;
      have_choice_in  = have_choice_ff;
      chosen_index_in = chosen_index_ff;
      chosen_app_in   = chosen_app_ff;
      chosen_task_in  = chosen_task_ff;
      slot_pos_in     = slot_pos_ff;
      if (consume) begin
         if (item.last_slot) begin
            best_excess_in  = 8'd0;
            have_choice_in  = 1'b0;
            chosen_index_in = 4'd0;
            chosen_app_in   = 8'd0;
            chosen_task_in  = 8'd0;
            slot_pos_in     = 4'd0;
         end else begin
            best_excess_in  = best_next;
            have_choice_in  = have_next;
            chosen_index_in = index_next;
            chosen_app_in   = app_next;
            chosen_task_in  = task_next;
            slot_pos_in     = (pos_plus >= 5'(POS_LIMIT)) ? 4'd0 : pos_plus[3:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_excess_ff  <= 8'd0;
         have_choice_ff  <= 1'b0;
         chosen_index_ff <= 4'd0;
         chosen_app_ff   <= 8'd0;
         chosen_task_ff  <= 8'd0;
         slot_pos_ff     <= 4'd0;
      end else begin
         best_excess_ff  <= best_excess_in;
         have_choice_ff  <= have_choice_in;
         chosen_index_ff <= chosen_index_in;
         chosen_app_ff   <= chosen_app_in;
         chosen_task_ff  <= chosen_task_in;
         slot_pos_ff     <= slot_pos_in;
      end
   end

endmodule

FILE: rtl/core/pvs_out_stage.sv
// Result register: holds one result item until the sink takes it.
// Depends on pvs_pkg and pvs_rsp_if.
module pvs_out_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  pvs_pkg::rsp_item_type rsp_item,
   output logic                  out_free,
   pvs_rsp_if.source             rsp_ch
);

   logic                  valid_ff;
   logic                  valid_in;
   pvs_pkg::rsp_item_type item_ff;

   assign out_free = !valid_ff || rsp_ch.ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= rsp_item;
      end
   end

   assign rsp_ch.valid         = valid_ff;
   assign rsp_ch.victim_found  = item_ff.victim_found;
   assign rsp_ch.victim_slot   = item_ff.victim_slot;
   assign rsp_ch.victim_excess = item_ff.victim_excess;

endmodule

FILE: rtl/core/preemption_victim_select_top.sv
// Top level of the preemption victim selector.
// Depends on pvs_pkg, pvs_req_if, pvs_rsp_if, pvs_in_stage, pvs_select and pvs_out_stage.
//
// Feed one item per fabric slot in scan order; the item flagged last_slot closes the scan and
// produces one result: whether a victim was found, its scan position and the largest excess
// (occupancy minus threshold) seen in waiting slots. The block takes one item per clock
// while no last item waits; a result is presented once its last item has passed the input
// register and the compare has loaded it into the result register, and a last item waits in
// the input register while an earlier result is still held. The scan position wraps at
// MAX_SLOTS or 16, whichever is smaller, and all scan state clears after each last item.
module preemption_victim_select_top #(
   parameter int MAX_SLOTS = 16
) (
   input  logic       clock,
   input  logic       reset,
   pvs_req_if.sink    req_ch,
   pvs_rsp_if.source  rsp_ch
);

   localparam int POS_LIMIT = (MAX_SLOTS < pvs_pkg::POS_CAP) ? MAX_SLOTS : pvs_pkg::POS_CAP;

   logic                  item_valid;
   pvs_pkg::req_item_type item;
   logic                  consume;
   logic                  rsp_load;
   pvs_pkg::rsp_item_type rsp_item;
   logic                  out_free;

   pvs_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .consume    (consume),
      .item_valid (item_valid),
      .item       (item)
   );

   pvs_select #(
      .POS_LIMIT (POS_LIMIT)
   ) u_select (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .out_free   (out_free),
      .consume    (consume),
      .rsp_load   (rsp_load),
      .rsp_item   (rsp_item)
   );

   pvs_out_stage u_out (
      .clock    (clock),
      .reset    (reset),
      .load     (rsp_load),
      .rsp_item (rsp_item),
      .out_free (out_free),
      .rsp_ch   (rsp_ch)
   );

   a_result_follows_last: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> rsp_ch.valid)
      else $error("result missing after last item");

   a_no_victim_slot_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.victim_found) |-> (rsp_ch.victim_slot == 4'd0))
      else $error("victim_slot set without a victim");

   a_victim_has_excess: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.victim_found) |-> (rsp_ch.victim_excess != 8'd0))
      else $error("victim chosen with zero excess");

   a_excess_bounded: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (rsp_ch.victim_excess <= 8'd31))
      else $error("excess above occupancy range");

   a_no_load_when_full: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> out_free)
      else $error("result register overwritten");

endmodule

FILE: tb/tb_top.sv
// Testbench for preemption_victim_select_top: drives slot scans over the req channel and
// checks each victim result against an internal predictor of the selection rules.
// Depends on pvs_pkg, pvs_req_if, pvs_rsp_if and the RTL top level.
`timescale 1ns / 1ps

class victim_scoreboard;
   int unsigned           slot_limit;
   logic [7:0]            best_excess;
   bit                    have_choice;
   logic [3:0]            chosen_index;
   logic [7:0]            chosen_app;
   logic [7:0]            chosen_task;
   logic [3:0]            position;
   pvs_pkg::rsp_item_type verdicts[$];
   int unsigned           mismatches;
   int unsigned           checked;

   function new(int unsigned limit);
      slot_limit = limit;
      mismatches = 0;
      checked    = 0;
      clear_scan();
   endfunction

   function void clear_scan();
      best_excess  = '0;
      have_choice  = 1'b0;
      chosen_index = '0;
      chosen_app   = '0;
      chosen_task  = '0;
      position     = '0;
   endfunction

   function void note_slot(pvs_pkg::req_item_type s);
      int                    excess;
      int unsigned           nxt;
      pvs_pkg::rsp_item_type v;
      excess = int'(s.app_occupancy) - int'(s.app_threshold);
      if (s.slot_status == pvs_pkg::ST_WAITING) begin
         if (excess > int'(best_excess)) begin
            best_excess  = 8'(excess);
            have_choice  = 1'b1;
            chosen_index = position;
            chosen_app   = s.app_id;
            chosen_task  = s.task_id;
         end else if (excess == int'(best_excess) && have_choice) begin
            if (s.app_id == chosen_app && s.task_id > chosen_task) begin
               chosen_index = position;
               chosen_task  = s.task_id;
            end
         end
      end
      if (have_choice && s.slot_status == pvs_pkg::ST_RUNNING) begin
         if (s.app_id == chosen_app && s.task_id > chosen_task)
            have_choice = 1'b0;
      end
      if (s.last_slot) begin
         v.victim_found  = have_choice;
         v.victim_slot   = have_choice ? chosen_index : 4'd0;
         v.victim_excess = best_excess;
         verdicts.insert(verdicts.size(), v);
         clear_scan();
      end else begin
         nxt = position + 1;
         if (nxt >= slot_limit)
            nxt = 0;
         position = 4'(nxt);
      end
   endfunction

   function void flag_mismatch(string what, pvs_pkg::rsp_item_type want,
                               pvs_pkg::rsp_item_type got);
      mismatches++;
      if (mismatches <= 10)
         $display("%0t MISMATCH %s: exp found=%0d slot=%0d excess=%0d, %s%0d %s%0d %s%0d",
                  $time, what, want.victim_found, want.victim_slot, want.victim_excess,
                  "got found=", got.victim_found, "slot=", got.victim_slot,
                  "excess=", got.victim_excess);
   endfunction

   function void check_verdict(pvs_pkg::rsp_item_type got);
      pvs_pkg::rsp_item_type want;
      if (verdicts.size() == 0) begin
         want = '0;
         flag_mismatch("unexpected result", want, got);
         return;
      end
      want = verdicts.pop_front();
      checked++;
      if (got.victim_found !== want.victim_found)
         flag_mismatch("victim_found", want, got);
      if (got.victim_slot !== want.victim_slot)
         flag_mismatch("victim_slot", want, got);
      if (got.victim_excess !== want.victim_excess)
         flag_mismatch("victim_excess", want, got);
   endfunction

   function int pending();
      return verdicts.size();
   endfunction
endclass

module tb_top;
   localparam int SLOT_COUNT  = 16;
   localparam int SLOT_LIMIT  = (SLOT_COUNT < pvs_pkg::POS_CAP) ? SLOT_COUNT : pvs_pkg::POS_CAP;
   localparam int ITEM_GOAL   = 1150;
   localparam int CYCLE_LIMIT = 200000;
   localparam logic [1:0] ST_SPARE = 2'd3;

   logic clock;
   logic reset;
   bit   quiet;
   int   items_sent;
   int   scans;
   int   cycle_count;

   pvs_req_if req_ch ();
   pvs_rsp_if rsp_ch ();

   victim_scoreboard sb = new(SLOT_LIMIT);

   preemption_victim_select_top #(.MAX_SLOTS(SLOT_COUNT)) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      pvs_pkg::req_item_type s;
      pvs_pkg::rsp_item_type r;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            s.slot_status   = req_ch.slot_status;
            s.app_id        = req_ch.app_id;
            s.task_id       = req_ch.task_id;
            s.app_occupancy = req_ch.app_occupancy;
            s.app_threshold = req_ch.app_threshold;
            s.last_slot     = req_ch.last_slot;
            sb.note_slot(s);
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            r.victim_found  = rsp_ch.victim_found;
            r.victim_slot   = rsp_ch.victim_slot;
            r.victim_excess = rsp_ch.victim_excess;
            sb.check_verdict(r);
         end
      end
   end

   // result side backpressure
   initial begin
      int stall;
      stall = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (quiet) begin
            rsp_ch.ready <= 1'b1;
         end else if (stall > 0) begin
            stall--;
            rsp_ch.ready <= 1'b0;
         end else if ($urandom_range(0, 5) == 0) begin
            stall = $urandom_range(1, 8) - 1;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("%0t timeout, %0d results outstanding", $time, sb.pending());
      $display("tb_top: errors");
      $finish;
   end

   task automatic send_slot(pvs_pkg::req_item_type s);
      req_ch.valid         <= 1'b1;
      req_ch.slot_status   <= s.slot_status;
      req_ch.app_id        <= s.app_id;
      req_ch.task_id       <= s.task_id;
      req_ch.app_occupancy <= s.app_occupancy;
      req_ch.app_threshold <= s.app_threshold;
      req_ch.last_slot     <= s.last_slot;
      @(posedge clock);
      while (!req_ch.ready)
         @(posedge clock);
      items_sent++;
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   endtask

   task automatic slot(logic [1:0] status, logic [7:0] app, logic [7:0] tsk,
                       logic [4:0] occ, logic [7:0] thr, logic last);
      pvs_pkg::req_item_type s;
      s.slot_status   = status;
      s.app_id        = app;
      s.task_id       = tsk;
      s.app_occupancy = occ;
      s.app_threshold = thr;
      s.last_slot     = last;
      send_slot(s);
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0)
         @(posedge clock);
   endtask

   task automatic random_scan();
      int                    len;
      int                    pick;
      bit                    shaped;
      logic [7:0]            focus_app;
      pvs_pkg::req_item_type s;
      shaped    = ($urandom_range(0, 9) < 8);
      len       = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 22) : $urandom_range(1, 8);
      focus_app = 8'($urandom);
      for (int i = 0; i < len; i++) begin
         pick = $urandom_range(0, 19);
         s.slot_status = (pick < 10) ? pvs_pkg::ST_WAITING :
                         (pick < 15) ? pvs_pkg::ST_RUNNING :
                         (pick < 18) ? pvs_pkg::ST_OTHER : ST_SPARE;
         s.last_slot = (i == len - 1);
         s.task_id   = 8'($urandom);
         if (shaped && $urandom_range(0, 9) < 8) begin
            s.app_id        = ($urandom_range(0, 4) == 0) ? 8'($urandom) : focus_app;
            s.app_threshold = 8'($urandom_range(0, 6));
            s.app_occupancy = 5'(s.app_threshold + $urandom_range(0, 3));
            if ($urandom_range(0, 15) == 0) begin
               s.app_threshold = 8'd0;
               s.app_occupancy = 5'($urandom_range(16, 31));
            end
         end else begin
            s.app_id        = 8'($urandom);
            s.app_occupancy = 5'($urandom_range(0, 31));
            s.app_threshold = 8'($urandom);
         end
         send_slot(s);
      end
      scans++;
   endtask

   initial begin
      quiet      = 1'b0;
      items_sent = 0;
      scans      = 0;
      reset                <= 1'b1;
      req_ch.valid         <= 1'b0;
      req_ch.slot_status   <= pvs_pkg::ST_OTHER;
      req_ch.app_id        <= '0;
      req_ch.task_id       <= '0;
      req_ch.app_occupancy <= '0;
      req_ch.app_threshold <= '0;
      req_ch.last_slot     <= 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // single waiting slot at full occupancy
      slot(pvs_pkg::ST_WAITING, 8'h00, 8'h00, 5'd16, 8'd0, 1'b1);
      // status three never chosen
      slot(ST_SPARE, 8'hFF, 8'hFF, 5'd31, 8'd0, 1'b1);
      // ties: later task of same app takes, earlier or other app does not; running clears
      slot(pvs_pkg::ST_WAITING, 8'd7, 8'd3, 5'd9, 8'd4, 1'b0);
      slot(pvs_pkg::ST_WAITING, 8'd7, 8'd9, 5'd5, 8'd0, 1'b0);
      slot(pvs_pkg::ST_WAITING, 8'd7, 8'd2, 5'd6, 8'd1, 1'b0);
      slot(pvs_pkg::ST_WAITING, 8'd8, 8'd200, 5'd5, 8'd0, 1'b0);
      slot(pvs_pkg::ST_RUNNING, 8'd7, 8'd10, 5'd0, 8'd0, 1'b0);
      slot(pvs_pkg::ST_OTHER, 8'd7, 8'd255, 5'd31, 8'd0, 1'b1);
      // negative excess, then max excess on the last slot
      slot(pvs_pkg::ST_WAITING, 8'd1, 8'd1, 5'd0, 8'd255, 1'b0);
      slot(pvs_pkg::ST_RUNNING, 8'd1, 8'd255, 5'd0, 8'd0, 1'b0);
      slot(pvs_pkg::ST_WAITING, 8'd255, 8'd255, 5'd31, 8'd0, 1'b1);
      // long scan, position wraps
      for (int i = 0; i < 17; i++) begin
         if (i == 3)
            slot(pvs_pkg::ST_WAITING, 8'd42, 8'd5, 5'd2, 8'd0, 1'b0);
         else if (i == 16)
            slot(pvs_pkg::ST_WAITING, 8'd42, 8'd6, 5'd3, 8'd1, 1'b1);
         else
            slot(pvs_pkg::ST_OTHER, 8'($urandom), 8'($urandom), 5'd20, 8'd0, 1'b0);
      end
      scans += 5;
      drain();

      while (items_sent < ITEM_GOAL) begin
         if (items_sent > (ITEM_GOAL * 7) / 8)
            quiet = 1'b1;
         random_scan();
         if (!quiet && $urandom_range(0, 39) == 0)
            drain();
      end

      quiet = 1'b1;
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);

      $display("Ran %0d scans (%0d slot items, directed ties, clears and wrap included),",
               scans, items_sent);
      $display("checked %0d victim results, %0d mismatches.", sb.checked, sb.mismatches);
      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("tb_top: clean");
      else
         $display("tb_top: errors");
      $finish;
   end
endmodule

FILE: filelist.f
rtl/core/pvs_pkg.sv
rtl/core/pvs_req_if.sv
rtl/core/pvs_rsp_if.sv
rtl/core/pvs_in_stage.sv
rtl/core/pvs_select.sv
rtl/core/pvs_out_stage.sv
rtl/core/preemption_victim_select_top.sv
tb/tb_top.sv
